// ----- hdl/sie_pkg.sv -----
// Sparse image expander: shared types and constants.
// Phase and chunk-kind enums, result kind and status codes, header words.
// No dependencies.
package sie_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CHUNK  = 3'd1,
        PH_RAW    = 3'd2,
        PH_FILL   = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5,
        PH_ERROR  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CK_RAW      = 2'd0,
        CK_FILL     = 2'd1,
        CK_DONTCARE = 2'd2,
        CK_CRC      = 2'd3
    } t_ckind;

    // result kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_FILL  = 3'd1;
    localparam logic [2:0] KIND_ZERO  = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MAGIC      = 3'd1;
    localparam logic [2:0] ST_VERSION    = 3'd2;
    localparam logic [2:0] ST_HDR_SIZE   = 3'd3;
    localparam logic [2:0] ST_CHUNK_TYPE = 3'd4;
    localparam logic [2:0] ST_FILL_SIZE  = 3'd5;
    localparam logic [2:0] ST_CHUNK_SIZE = 3'd6;
    localparam logic [2:0] ST_TRUNCATED  = 3'd7;

    // file header word positions
    localparam logic [2:0] HW_MAGIC   = 3'd0;
    localparam logic [2:0] HW_VERSION = 3'd1;
    localparam logic [2:0] HW_HSIZE   = 3'd2;
    localparam logic [2:0] HW_BLKSZ   = 3'd3;
    localparam logic [2:0] HW_NCHUNK  = 3'd5;
    localparam logic [2:0] HW_LAST    = 3'd6;

    // chunk header word positions
    localparam logic [2:0] CW_TYPE   = 3'd0;
    localparam logic [2:0] CW_BLOCKS = 3'd1;

    localparam logic [31:0] MAGIC_WORD      = 32'hed26ff3a;
    localparam logic [15:0] VER_MAJOR       = 16'd1;
    localparam logic [15:0] VER_MINOR       = 16'd0;
    localparam logic [15:0] FILE_HDR_BYTES  = 16'd28;
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd12;
    localparam logic [31:0] FILL_BYTES      = 32'd4;
    localparam logic [31:0] WORD_BYTES      = 32'd4;

    localparam logic [15:0] TYPE_RAW      = 16'hCAC1;
    localparam logic [15:0] TYPE_FILL     = 16'hCAC2;
    localparam logic [15:0] TYPE_DONTCARE = 16'hCAC3;
    localparam logic [15:0] TYPE_CRC      = 16'hCAC4;

endpackage

// ----- hdl/sie_out_fifo.sv -----
// Sparse image expander: four-entry result queue, up to two pushes and one pop a cycle.
// Parts the parser from the output stream. No package dependency.
module sie_out_fifo #(
    parameter int WIDTH = 167
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_wr_cnt,
    input  logic [WIDTH-1:0] i_wr0,
    input  logic [WIDTH-1:0] i_wr1,
    output logic [2:0]       o_count,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);

    logic [WIDTH-1:0] r_mem [4];
    logic [1:0]       r_wp;
    logic [1:0]       r_rp;
    logic [2:0]       r_count;
    logic             pop;

    assign pop     = (r_count != 3'd0) && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + i_wr_cnt;
            r_rp    <= r_rp + 2'(pop);
            r_count <= r_count + 3'(i_wr_cnt) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_wr1;
        end
    end

endmodule

// ----- hdl/sie_parser.sv -----
// Sparse image expander: parse state and one-word update, up to two results per word.
// Uses sie_pkg. Results are packed {kind, last, status, payload, run, offset}.
module sie_parser #(
    parameter int OFFSET_BITS = 64,
    parameter int RES_W       = OFFSET_BITS + 103
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [31:0]      i_word,
    input  logic             i_final,
    input  logic             i_skip_dc,
    output logic [1:0]       o_cnt,
    output logic [RES_W-1:0] o_res0,
    output logic [RES_W-1:0] o_res1
);

    sie_pkg::t_phase         r_phase, n_phase;
    sie_pkg::t_ckind         r_ckind, n_ckind;
    logic [2:0]              r_wpos, n_wpos;
    logic [31:0]             r_block_bytes, n_block_bytes;
    logic [31:0]             r_chunks, n_chunks;
    logic [31:0]             r_left, n_left;
    logic [63:0]             r_run, n_run;
    logic [OFFSET_BITS-1:0]  r_wr_pos, n_wr_pos;

    logic [63:0]             prod;
    logic [63:0]             adv_amt;
    logic [31:0]             left_dec;
    logic [31:0]             chunk_left;
    logic                    ce;
    logic                    p_valid, d_valid, t_valid;
    logic [2:0]              p_kind, p_status;
    logic [63:0]             p_run;
    logic [31:0]             p_pay;
    logic [RES_W-1:0]        res_p, res_d, res_t;

    function automatic logic [RES_W-1:0] pack_res(
        input logic [2:0]             kind,
        input logic                   last,
        input logic [2:0]             status,
        input logic [31:0]            pay,
        input logic [63:0]            run,
        input logic [OFFSET_BITS-1:0] off
    );
        return {kind, last, status, pay, run, off};
    endfunction

    // chunk run length, registered on the blocks word
    assign prod       = 64'(i_word) * 64'(r_block_bytes);
    assign left_dec   = (r_left >= sie_pkg::WORD_BYTES) ? r_left - sie_pkg::WORD_BYTES : 32'd0;
    assign chunk_left = i_word - sie_pkg::CHUNK_HDR_BYTES;

    always_comb begin
        n_phase       = r_phase;
        n_ckind       = r_ckind;
        n_wpos        = r_wpos;
        n_block_bytes = r_block_bytes;
        n_chunks      = r_chunks;
        n_left        = r_left;
        n_run         = r_run;
        adv_amt       = '0;
        ce            = 1'b0;
        p_valid       = 1'b0;
        d_valid       = 1'b0;
        p_kind        = sie_pkg::KIND_DATA;
        p_status      = sie_pkg::ST_OK;
        p_run         = '0;
        p_pay         = '0;

        if (i_valid) begin
            case (r_phase)
                sie_pkg::PH_HEADER: begin
                    n_wpos = r_wpos + 3'd1;
                    case (r_wpos)
                        sie_pkg::HW_MAGIC: begin
                            if (i_word != sie_pkg::MAGIC_WORD) begin
                                n_phase  = sie_pkg::PH_ERROR;
                                p_valid  = 1'b1;
                                p_kind   = sie_pkg::KIND_ERROR;
                                p_status = sie_pkg::ST_MAGIC;
                            end
                        end
                        sie_pkg::HW_VERSION: begin
                            if (i_word[15:0] != sie_pkg::VER_MAJOR ||
                                i_word[31:16] != sie_pkg::VER_MINOR) begin
                                n_phase  = sie_pkg::PH_ERROR;
                                p_valid  = 1'b1;
                                p_kind   = sie_pkg::KIND_ERROR;
                                p_status = sie_pkg::ST_VERSION;
                            end
                        end
                        sie_pkg::HW_HSIZE: begin
                            if (i_word[15:0] != sie_pkg::FILE_HDR_BYTES) begin
                                n_phase  = sie_pkg::PH_ERROR;
                                p_valid  = 1'b1;
                                p_kind   = sie_pkg::KIND_ERROR;
                                p_status = sie_pkg::ST_HDR_SIZE;
                            end
                        end
                        sie_pkg::HW_BLKSZ:  n_block_bytes = i_word;
                        sie_pkg::HW_NCHUNK: n_chunks = i_word;
                        sie_pkg::HW_LAST: begin
                            n_wpos = '0;
                            if (r_chunks == 32'd0) begin
                                n_phase = sie_pkg::PH_DONE;
                                d_valid = 1'b1;
                            end else begin
                                n_phase = sie_pkg::PH_CHUNK;
                            end
                        end
                        default: ;
                    endcase
                end

                sie_pkg::PH_CHUNK: begin
                    case (r_wpos)
                        sie_pkg::CW_TYPE: begin
                            n_wpos = sie_pkg::CW_BLOCKS;
                            case (i_word[15:0])
                                sie_pkg::TYPE_RAW:      n_ckind = sie_pkg::CK_RAW;
                                sie_pkg::TYPE_FILL:     n_ckind = sie_pkg::CK_FILL;
                                sie_pkg::TYPE_DONTCARE: n_ckind = sie_pkg::CK_DONTCARE;
                                sie_pkg::TYPE_CRC:      n_ckind = sie_pkg::CK_CRC;
                                default: begin
                                    n_wpos   = r_wpos;
                                    n_phase  = sie_pkg::PH_ERROR;
                                    p_valid  = 1'b1;
                                    p_kind   = sie_pkg::KIND_ERROR;
                                    p_status = sie_pkg::ST_CHUNK_TYPE;
                                end
                            endcase
                        end
                        sie_pkg::CW_BLOCKS: begin
                            n_run  = prod;
                            n_wpos = r_wpos + 3'd1;
                        end
                        default: begin
                            // total-size word: payload length decides the next phase
                            n_wpos = '0;
                            n_left = chunk_left;
                            if (i_word < sie_pkg::CHUNK_HDR_BYTES) begin
                                n_left   = r_left;
                                n_phase  = sie_pkg::PH_ERROR;
                                p_valid  = 1'b1;
                                p_kind   = sie_pkg::KIND_ERROR;
                                p_status = sie_pkg::ST_CHUNK_SIZE;
                            end else begin
                                case (r_ckind)
                                    sie_pkg::CK_RAW: begin
                                        if (chunk_left[1:0] != 2'd0) begin
                                            n_phase  = sie_pkg::PH_ERROR;
                                            p_valid  = 1'b1;
                                            p_kind   = sie_pkg::KIND_ERROR;
                                            p_status = sie_pkg::ST_CHUNK_SIZE;
                                        end else if (chunk_left == 32'd0) begin
                                            ce = 1'b1;
                                        end else begin
                                            n_phase = sie_pkg::PH_RAW;
                                        end
                                    end
                                    sie_pkg::CK_FILL: begin
                                        if (chunk_left != sie_pkg::FILL_BYTES) begin
                                            n_phase  = sie_pkg::PH_ERROR;
                                            p_valid  = 1'b1;
                                            p_kind   = sie_pkg::KIND_ERROR;
                                            p_status = sie_pkg::ST_FILL_SIZE;
                                        end else begin
                                            n_phase = sie_pkg::PH_FILL;
                                        end
                                    end
                                    default: begin
                                        // don't-care and CRC: maybe a zero run, then skip any payload
                                        if (r_ckind == sie_pkg::CK_DONTCARE) begin
                                            adv_amt = r_run;
                                            if (!i_skip_dc) begin
                                                p_valid = 1'b1;
                                                p_kind  = sie_pkg::KIND_ZERO;
                                                p_run   = r_run;
                                            end
                                        end
                                        if (chunk_left == 32'd0) begin
                                            ce = 1'b1;
                                        end else begin
                                            n_phase = sie_pkg::PH_SKIP;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end

                sie_pkg::PH_RAW: begin
                    p_valid = 1'b1;
                    p_kind  = sie_pkg::KIND_DATA;
                    p_run   = 64'(sie_pkg::WORD_BYTES);
                    p_pay   = i_word;
                    adv_amt = 64'(sie_pkg::WORD_BYTES);
                    n_left  = left_dec;
                    ce      = (left_dec == 32'd0);
                end

                sie_pkg::PH_FILL: begin
                    p_valid = 1'b1;
                    p_kind  = sie_pkg::KIND_FILL;
                    p_run   = r_run;
                    p_pay   = i_word;
                    adv_amt = r_run;
                    n_left  = '0;
                    ce      = 1'b1;
                end

                sie_pkg::PH_SKIP: begin
                    n_left = left_dec;
                    ce     = (left_dec == 32'd0);
                end

                default: ;
            endcase
        end

        n_wr_pos = r_wr_pos + adv_amt[OFFSET_BITS-1:0];

        if (ce) begin
            n_chunks = r_chunks - 32'd1;
            n_wpos   = '0;
            if (n_chunks == 32'd0) begin
                n_phase = sie_pkg::PH_DONE;
                d_valid = 1'b1;
            end else begin
                n_phase = sie_pkg::PH_CHUNK;
            end
        end

        t_valid = i_valid && i_final &&
                  r_phase != sie_pkg::PH_DONE && r_phase != sie_pkg::PH_ERROR &&
                  n_phase != sie_pkg::PH_DONE && n_phase != sie_pkg::PH_ERROR;
        if (t_valid) begin
            n_phase = sie_pkg::PH_ERROR;
        end
    end

    // primary result, then done, then truncation; at most two are set
    always_comb begin
        o_cnt = 2'(p_valid) + 2'(d_valid) + 2'(t_valid);
        res_p = pack_res(p_kind, o_cnt == 2'd1, p_status, p_pay, p_run, r_wr_pos);
        res_d = pack_res(sie_pkg::KIND_DONE, 1'b1, sie_pkg::ST_OK, '0, '0, n_wr_pos);
        res_t = pack_res(sie_pkg::KIND_ERROR, 1'b1, sie_pkg::ST_TRUNCATED, '0, '0, n_wr_pos);
        if (p_valid) begin
            o_res0 = res_p;
            o_res1 = d_valid ? res_d : res_t;
        end else begin
            o_res0 = d_valid ? res_d : res_t;
            o_res1 = res_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sie_pkg::PH_HEADER;
            r_ckind       <= sie_pkg::CK_RAW;
            r_wpos        <= '0;
            r_block_bytes <= '0;
            r_chunks      <= '0;
            r_left        <= '0;
            r_run         <= '0;
            r_wr_pos      <= '0;
        end else begin
            r_phase       <= n_phase;
            r_ckind       <= n_ckind;
            r_wpos        <= n_wpos;
            r_block_bytes <= n_block_bytes;
            r_chunks      <= n_chunks;
            r_left        <= n_left;
            r_run         <= n_run;
            r_wr_pos      <= n_wr_pos;
        end
    end

endmodule

// ----- hdl/sparse_image_expander.sv -----
// Sparse image expander top level: input register, parser, result queue, config register.
// Uses sie_parser and sie_out_fifo; sie_pkg only through the parser.
//
//  channel   direction  signals                              request
//  s_axis    in         tvalid tready tdata tlast            one image word
//  m_axis    out        tvalid tready tdata tuser tlast      one expanded-image result
//  cfg       in         i_cfg_we i_cfg_wdata                 skip_dont_care write
//
// One word per cycle is taken while the queue has room; words are parsed from a register.
// A word yields zero, one or two results; the output side drains one per cycle,
// so words yielding two results limit the rate to one result per cycle.
// Words are parsed only while the four-entry result queue has room for two.
// Reset (synchronous, active low) returns to the header phase with offset zero.
module sparse_image_expander #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,     // skip_dont_care
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,    // word
    input  logic                    s_axis_tlast,    // final_word
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // out_offset, run_bytes[63:0], payload[31:0], status[2:0], zero pad
    output logic [((OFFSET_BITS + 99 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [2:0]              m_axis_tuser,    // kind
    output logic                    m_axis_tlast     // last_of_item
);

    localparam int TDATA_W = ((OFFSET_BITS + 99 + 7) / 8) * 8;
    localparam int RES_W   = OFFSET_BITS + 103;

    logic               r_skip_dc;
    logic               r_in_valid;
    logic [31:0]        r_in_word;
    logic               r_in_final;
    logic               consume;
    logic [2:0]         q_count;
    logic [1:0]         res_cnt;
    logic [RES_W-1:0]   res0, res1;
    logic [RES_W-1:0]   q_data;

    assign consume       = r_in_valid && (q_count <= 3'd2);
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_dc  <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_skip_dc <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word  <= s_axis_tdata;
            r_in_final <= s_axis_tlast;
        end
    end

    sie_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .RES_W       (RES_W)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (consume),
        .i_word    (r_in_word),
        .i_final   (r_in_final),
        .i_skip_dc (r_skip_dc),
        .o_cnt     (res_cnt),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    sie_out_fifo #(
        .WIDTH (RES_W)
    ) u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (res_cnt),
        .i_wr0    (res0),
        .i_wr1    (res1),
        .o_count  (q_count),
        .o_valid  (m_axis_tvalid),
        .o_data   (q_data),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = TDATA_W'(q_data[OFFSET_BITS+98:0]);
    assign m_axis_tlast = q_data[OFFSET_BITS+99];
    assign m_axis_tuser = q_data[OFFSET_BITS+102:OFFSET_BITS+100];

endmodule

// ----- sim/tb_sparse_image_expander.sv -----
// Self-checking testbench for sparse_image_expander: streams one generated sparse image,
// predicts every result in a scoreboard class and checks the result stream field by field.
// Depends on sie_pkg and the sparse_image_expander RTL.
`timescale 1ns / 1ps

module tb_sparse_image_expander;

    localparam int           RESULT_W    = 168;      // 163 bits of fields, padded to bytes
    localparam int           HOLD_CYCLES = 300;
    localparam int           SETTLE      = 8;
    localparam logic [2:0]   CW_TOTAL    = 3'd2;     // chunk header: total bytes word
    localparam logic [31:0]  STD_BLOCK   = 32'd4096;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] offset;
        logic [63:0] run;
        logic [31:0] payload;
        logic [2:0]  status;
        logic        item_last;
    } t_op;

    // Expected-operation store plus a model of the parser that fills it.
    class expansion_scoreboard;
        sie_pkg::t_phase phase;
        sie_pkg::t_ckind ck_kind;
        logic [2:0]  wpos;
        logic [31:0] blk_bytes;
        logic [31:0] chunks_left;
        logic [31:0] ck_blocks;
        logic [31:0] pay_left;
        logic [63:0] wr_pos;
        bit          skip_dc;
        t_op         expected_ops[$];
        int          mismatches;
        int          words_seen;
        int          words_ignored;
        int          kind_seen[5];
        logic [2:0]  end_status;

        function new();
            phase       = sie_pkg::PH_HEADER;
            ck_kind     = sie_pkg::CK_RAW;
            wpos        = '0;
            blk_bytes   = '0;
            chunks_left = '0;
            ck_blocks   = '0;
            pay_left    = '0;
            wr_pos      = '0;
            skip_dc     = 1'b0;
            mismatches  = 0;
            words_seen  = 0;
            words_ignored = 0;
            end_status  = sie_pkg::ST_OK;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function int outstanding();
            return expected_ops.size();
        endfunction

        function void add_op(logic [2:0] kind, logic [63:0] off, logic [63:0] run,
                             logic [31:0] pay, logic [2:0] st);
            t_op r;
            r.kind = kind;
            r.offset = off;
            r.run = run;
            r.payload = pay;
            r.status = st;
            r.item_last = 1'b0;
            expected_ops.push_back(r);
        endfunction

        function void raise_error(logic [2:0] st);
            phase = sie_pkg::PH_ERROR;
            add_op(sie_pkg::KIND_ERROR, wr_pos, 64'd0, 32'd0, st);
        endfunction

        function void close_chunk();
            chunks_left = chunks_left - 32'd1;
            wpos = '0;
            if (chunks_left == 32'd0) begin
                phase = sie_pkg::PH_DONE;
                add_op(sie_pkg::KIND_DONE, wr_pos, 64'd0, 32'd0, sie_pkg::ST_OK);
            end else begin
                phase = sie_pkg::PH_CHUNK;
            end
        endfunction

        function void file_header_word(logic [31:0] w);
            case (wpos)
                sie_pkg::HW_MAGIC: begin
                    if (w != sie_pkg::MAGIC_WORD) begin
                        raise_error(sie_pkg::ST_MAGIC);
                        return;
                    end
                end
                sie_pkg::HW_VERSION: begin
                    if (w[15:0] != sie_pkg::VER_MAJOR || w[31:16] != sie_pkg::VER_MINOR) begin
                        raise_error(sie_pkg::ST_VERSION);
                        return;
                    end
                end
                sie_pkg::HW_HSIZE: begin
                    if (w[15:0] != sie_pkg::FILE_HDR_BYTES) begin
                        raise_error(sie_pkg::ST_HDR_SIZE);
                        return;
                    end
                end
                sie_pkg::HW_BLKSZ:  blk_bytes = w;
                sie_pkg::HW_NCHUNK: chunks_left = w;
                sie_pkg::HW_LAST: begin
                    wpos = '0;
                    if (chunks_left == 32'd0) begin
                        phase = sie_pkg::PH_DONE;
                        add_op(sie_pkg::KIND_DONE, wr_pos, 64'd0, 32'd0, sie_pkg::ST_OK);
                    end else begin
                        phase = sie_pkg::PH_CHUNK;
                    end
                    return;
                end
                default: ;
            endcase
            wpos = wpos + 3'd1;
        endfunction

        function void chunk_header_word(logic [31:0] w);
            logic [63:0] run;
            if (wpos == sie_pkg::CW_TYPE) begin
                case (w[15:0])
                    sie_pkg::TYPE_RAW:      ck_kind = sie_pkg::CK_RAW;
                    sie_pkg::TYPE_FILL:     ck_kind = sie_pkg::CK_FILL;
                    sie_pkg::TYPE_DONTCARE: ck_kind = sie_pkg::CK_DONTCARE;
                    sie_pkg::TYPE_CRC:      ck_kind = sie_pkg::CK_CRC;
                    default: begin
                        raise_error(sie_pkg::ST_CHUNK_TYPE);
                        return;
                    end
                endcase
                wpos = sie_pkg::CW_BLOCKS;
                return;
            end
            if (wpos == sie_pkg::CW_BLOCKS) begin
                ck_blocks = w;
                wpos = CW_TOTAL;
                return;
            end
            wpos = sie_pkg::CW_TYPE;
            if (w < sie_pkg::CHUNK_HDR_BYTES) begin
                raise_error(sie_pkg::ST_CHUNK_SIZE);
                return;
            end
            pay_left = w - sie_pkg::CHUNK_HDR_BYTES;
            run = 64'(ck_blocks) * 64'(blk_bytes);
            case (ck_kind)
                sie_pkg::CK_RAW: begin
                    if (pay_left[1:0] != 2'b00) raise_error(sie_pkg::ST_CHUNK_SIZE);
                    else if (pay_left == 32'd0) close_chunk();
                    else phase = sie_pkg::PH_RAW;
                    return;
                end
                sie_pkg::CK_FILL: begin
                    if (pay_left != sie_pkg::FILL_BYTES) raise_error(sie_pkg::ST_FILL_SIZE);
                    else phase = sie_pkg::PH_FILL;
                    return;
                end
                sie_pkg::CK_DONTCARE: begin
                    if (!skip_dc) add_op(sie_pkg::KIND_ZERO, wr_pos, run, 32'd0, sie_pkg::ST_OK);
                    wr_pos = wr_pos + run;
                end
                default: ;
            endcase
            if (pay_left == 32'd0) close_chunk();
            else phase = sie_pkg::PH_SKIP;
        endfunction

        // An accepted image word: work out the operations it causes.
        function void note_word(logic [31:0] w, logic fin);
            int          first;
            logic [63:0] run;
            t_op         r;
            words_seen++;
            if (phase == sie_pkg::PH_DONE || phase == sie_pkg::PH_ERROR) begin
                words_ignored++;
                return;
            end
            first = expected_ops.size();
            case (phase)
                sie_pkg::PH_HEADER: file_header_word(w);
                sie_pkg::PH_CHUNK:  chunk_header_word(w);
                sie_pkg::PH_RAW: begin
                    add_op(sie_pkg::KIND_DATA, wr_pos, 64'd4, w, sie_pkg::ST_OK);
                    wr_pos = wr_pos + 64'd4;
                    pay_left = (pay_left >= sie_pkg::WORD_BYTES) ?
                               pay_left - sie_pkg::WORD_BYTES : 32'd0;
                    if (pay_left == 32'd0) close_chunk();
                end
                sie_pkg::PH_FILL: begin
                    run = 64'(ck_blocks) * 64'(blk_bytes);
                    add_op(sie_pkg::KIND_FILL, wr_pos, run, w, sie_pkg::ST_OK);
                    wr_pos = wr_pos + run;
                    pay_left = 32'd0;
                    close_chunk();
                end
                sie_pkg::PH_SKIP: begin
                    pay_left = (pay_left >= sie_pkg::WORD_BYTES) ?
                               pay_left - sie_pkg::WORD_BYTES : 32'd0;
                    if (pay_left == 32'd0) close_chunk();
                end
                default: ;
            endcase
            if (fin && phase != sie_pkg::PH_DONE && phase != sie_pkg::PH_ERROR) begin
                raise_error(sie_pkg::ST_TRUNCATED);
            end
            if (expected_ops.size() > first) begin
                r = expected_ops.pop_back();
                r.item_last = 1'b1;
                expected_ops.push_back(r);
            end
        endfunction

        function void check_op(t_op got);
            t_op exp_op;
            if (expected_ops.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result kind=%0d offset=%h run=%h", $time,
                         got.kind, got.offset, got.run);
                $display("%0t:   payload=%h status=%0d", $time, got.payload, got.status);
                return;
            end
            exp_op = expected_ops.pop_front();
            if (got.kind <= sie_pkg::KIND_ERROR) kind_seen[got.kind]++;
            if (got.kind == sie_pkg::KIND_ERROR) end_status = got.status;
            if (got.kind !== exp_op.kind) begin
                mismatches++;
                $display("%0t: kind expected %0d actual %0d", $time, exp_op.kind, got.kind);
            end
            if (got.offset !== exp_op.offset) begin
                mismatches++;
                $display("%0t: offset expected %h actual %h", $time, exp_op.offset, got.offset);
            end
            if (got.run !== exp_op.run) begin
                mismatches++;
                $display("%0t: run_bytes expected %h actual %h", $time, exp_op.run, got.run);
            end
            if (got.payload !== exp_op.payload) begin
                mismatches++;
                $display("%0t: payload expected %h actual %h", $time, exp_op.payload,
                         got.payload);
            end
            if (got.status !== exp_op.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, exp_op.status,
                         got.status);
            end
            if (got.item_last !== exp_op.item_last) begin
                mismatches++;
                $display("%0t: last_of_item expected %0d actual %0d", $time,
                         exp_op.item_last, got.item_last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;    // word
    logic                s_axis_tlast;    // final_word
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // out_offset[63:0], run_bytes[63:0], payload[31:0], status[2:0], zero pad
    logic [RESULT_W-1:0] m_axis_tdata;
    logic [2:0]          m_axis_tuser;    // kind
    logic                m_axis_tlast;    // last_of_item

    expansion_scoreboard sb;

    logic [31:0] image_words[$];
    logic        image_last[$];
    int          cfg_at[$];
    bit          cfg_val[$];
    int          image_chunks;
    int          cfg_writes;
    bit          hold_off_req;
    bit          tx_burst;

    sparse_image_expander u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #(7_200_000);
        $display("timeout waiting for the result stream");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Chunk header plus nwords random payload words.
    task automatic push_chunk(logic [15:0] ctype, logic [31:0] blocks, logic [31:0] total,
                              int nwords);
        logic [15:0] hi;
        hi = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
        image_words.push_back({hi, ctype});
        image_words.push_back(blocks);
        image_words.push_back(total);
        repeat (nwords) image_words.push_back($urandom);
        image_chunks++;
    endtask

    function automatic logic [31:0] pick_blocks();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'hFFFF_FFFF;
        if (r == 1) return $urandom;
        return $urandom_range(0, 16);
    endfunction

    task automatic build_image();
        int          r;
        int          n;
        int          since_cfg;
        int          ending;
        bit          next_skip;
        logic [31:0] bsz;

        r = $urandom_range(0, 3);
        bsz = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'($urandom) : STD_BLOCK;
        image_words.push_back(sie_pkg::MAGIC_WORD);
        image_words.push_back({sie_pkg::VER_MINOR, sie_pkg::VER_MAJOR});
        image_words.push_back({16'($urandom), sie_pkg::FILE_HDR_BYTES});
        image_words.push_back(bsz);
        image_words.push_back($urandom);          // total blocks, not checked
        image_words.push_back(32'd0);             // chunk count, patched below
        image_words.push_back($urandom);          // checksum, not checked

        // directed: data extremes, empty and huge runs, partial skip word, crc
        push_chunk(sie_pkg::TYPE_RAW, $urandom, 32'd20, 0);
        image_words.push_back(32'h0000_0000);
        image_words.push_back(32'hFFFF_FFFF);
        push_chunk(sie_pkg::TYPE_RAW, 32'd1, sie_pkg::CHUNK_HDR_BYTES, 0);
        push_chunk(sie_pkg::TYPE_FILL, 32'd0, 32'd16, 0);
        image_words.push_back(32'hFFFF_FFFF);
        push_chunk(sie_pkg::TYPE_FILL, 32'hFFFF_FFFF, 32'd16, 0);
        image_words.push_back(32'hA5A5_5A5A);
        push_chunk(sie_pkg::TYPE_DONTCARE, 32'd0, 32'd13, 1);
        push_chunk(sie_pkg::TYPE_DONTCARE, 32'd3, sie_pkg::CHUNK_HDR_BYTES, 0);
        push_chunk(sie_pkg::TYPE_CRC, 32'd0, 32'd16, 1);

        next_skip = 1'b1;
        cfg_at.push_back(image_words.size());
        cfg_val.push_back(next_skip);
        since_cfg = 0;

        while (image_words.size() < 1440) begin
            if (since_cfg > 350) begin
                next_skip = !next_skip;
                cfg_at.push_back(image_words.size());
                cfg_val.push_back(next_skip);
                since_cfg = 0;
            end
            n = image_words.size();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
                push_chunk(sie_pkg::TYPE_RAW, $urandom,
                           sie_pkg::CHUNK_HDR_BYTES + 32'(4 * r), r);
            end else if (r < 65) begin
                push_chunk(sie_pkg::TYPE_FILL, pick_blocks(), 32'd16, 1);
            end else if (r < 85) begin
                r = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
                push_chunk(sie_pkg::TYPE_DONTCARE, pick_blocks(),
                           sie_pkg::CHUNK_HDR_BYTES + 32'(r), (r + 3) / 4);
            end else begin
                r = ($urandom_range(0, 1) == 0) ? 4 : $urandom_range(0, 12);
                push_chunk(sie_pkg::TYPE_CRC, $urandom,
                           sie_pkg::CHUNK_HDR_BYTES + 32'(r), (r + 3) / 4);
            end
            since_cfg += image_words.size() - n;
        end

        // how the image ends: done, truncation, or one of the chunk errors
        ending = $urandom_range(0, 5);
        n = image_chunks;
        case (ending)
            0: image_words[5] = n;
            1: image_words[5] = n + 1;
            2: begin
                image_words[5] = n + 1 + $urandom_range(0, 3);
                image_words.push_back({16'($urandom),
                                       16'($urandom_range(0, sie_pkg::TYPE_RAW - 16'd1))});
            end
            3: begin
                image_words[5] = n + 1 + $urandom_range(0, 3);
                push_chunk(sie_pkg::TYPE_RAW, $urandom, $urandom_range(0, 11), 0);
            end
            4: begin
                image_words[5] = n + 1 + $urandom_range(0, 3);
                push_chunk(sie_pkg::TYPE_RAW, $urandom,
                           sie_pkg::CHUNK_HDR_BYTES +
                           32'(4 * $urandom_range(0, 4) + $urandom_range(1, 3)),
                           0);
            end
            default: begin
                image_words[5] = n + 1 + $urandom_range(0, 3);
                r = $urandom_range(0, 2);
                push_chunk(sie_pkg::TYPE_FILL, $urandom,
                           (r == 0) ? 32'd12 : (r == 1) ? 32'd20 : 32'd13, 0);
            end
        endcase
        foreach (image_words[i]) image_last.push_back(i == image_words.size() - 1);
        // trailing words after the end are ignored by the block
        repeat (8) begin
            image_words.push_back($urandom);
            image_last.push_back($urandom_range(0, 1));
        end
    endtask

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        return tx_burst ? 0 : $urandom_range(0, 11);
    endfunction

    // One request on the input side; returns at the edge it is taken.
    task automatic send_word(logic [31:0] w, logic fin);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(w, fin);
    endtask

    task automatic write_skip(bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.skip_dc = v;
        cfg_writes++;
    endtask

    // Stop the input, let the block drain, then change the register.
    task automatic pause_and_write(bit v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_skip(v);
    endtask

    initial begin : result_sink
        int  stall;
        bit  burst;
        t_op got;
        m_axis_tready = 1'b0;
        burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 11);
            if (hold_off_req) begin
                stall = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.offset    = m_axis_tdata[63:0];
            got.run       = m_axis_tdata[127:64];
            got.payload   = m_axis_tdata[159:128];
            got.status    = m_axis_tdata[162:160];
            got.kind      = m_axis_tuser;
            got.item_last = m_axis_tlast;
            sb.check_op(got);
        end
    end

    initial begin : stimulus
        int cfg_idx;
        int guard;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_off_req  = 1'b0;
        tx_burst      = 1'b0;
        image_chunks  = 0;
        cfg_writes    = 0;
        cfg_idx       = 0;
        build_image();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_skip(1'b0);

        foreach (image_words[i]) begin
            if (cfg_idx < cfg_at.size() && cfg_at[cfg_idx] == i) begin
                pause_and_write(cfg_val[cfg_idx]);
                cfg_idx++;
            end
            // long receiver stall mid-stream so the result queue backs up
            if (i == image_words.size() / 2) hold_off_req = 1'b1;
            send_word(image_words[i], image_last[i]);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.outstanding() > 0) @(posedge i_clk);
        guard = 0;
        while (guard < 40) begin
            @(posedge i_clk);
            guard++;
        end

        $display("Streamed %0d words in %0d chunks (%0d past the end), %0d reg writes",
                 sb.words_seen, image_chunks, sb.words_ignored, cfg_writes);
        $display("Checked data %0d, fill %0d, zero %0d, done %0d, error %0d (status %0d)",
                 sb.kind_seen[sie_pkg::KIND_DATA], sb.kind_seen[sie_pkg::KIND_FILL],
                 sb.kind_seen[sie_pkg::KIND_ZERO], sb.kind_seen[sie_pkg::KIND_DONE],
                 sb.kind_seen[sie_pkg::KIND_ERROR], sb.end_status);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sparse_image_expander.f -----
hdl/sie_pkg.sv
hdl/sie_out_fifo.sv
hdl/sie_parser.sv
hdl/sparse_image_expander.sv
sim/tb_sparse_image_expander.sv
